>>> rtl/csse_pkg.sv
package csse_pkg;

    localparam int DATA_W = 32;
    localparam int WGT_W = 28;
    localparam int ACC_W = 64;
    localparam int MAX_POINTS_DEF = 64;

    localparam logic [2:0] OP_WR_POINT = 3'd0;
    localparam logic [2:0] OP_WR_CTRL = 3'd1;
    localparam logic [2:0] OP_APPEND = 3'd2;
    localparam logic [2:0] OP_RD_POINT = 3'd3;
    localparam logic [2:0] OP_RD_CTRL = 3'd4;
    localparam logic [2:0] OP_POSITION = 3'd5;
    localparam logic [2:0] OP_GRADIENT = 3'd6;
    localparam logic [2:0] OP_HESSIAN = 3'd7;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic signed [WGT_W-1:0] weight_t;
    typedef logic signed [DATA_W-1:0] coord_t;
    typedef logic [3*DATA_W-1:0] vec_t;

    function automatic coord_t sat64(input logic signed [ACC_W-1:0] v);
        coord_t r;
        if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic coord_t reflect(input coord_t p, input coord_t c);
        logic signed [DATA_W+1:0] v;
        coord_t r;
        v = $signed({p[DATA_W-1], p, 1'b0}) - $signed({{2{c[DATA_W-1]}}, c});
        if (v > 34'sd2147483647) r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648) r = 32'sh80000000;
        else r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/csse_weights.sv
module csse_weights
    import csse_pkg::*;
(
    input  logic        clk,
    input  logic [2:0]  opcode,
    input  logic [15:0] frac,
    output weight_t     weights [4]
);

    logic [16:0] t1_reg, t2_reg;
    logic [33:0] sq1_reg, sq2_reg, m_reg;
    logic [2:0]  op_reg;
    logic [16:0] t1_a, t2_a;
    logic signed [ACC_W-1:0] a1, a2, s1, s2, mm;
    logic signed [ACC_W-1:0] e [4];
    weight_t w_reg [4];

    assign t2_a = {1'b0, frac};
    assign t1_a = 17'h10000 - t2_a;

    always_ff @(posedge clk)
    begin
        t1_reg <= t1_a;
        t2_reg <= t2_a;
        sq1_reg <= t1_a * t1_a;
        sq2_reg <= t2_a * t2_a;
        m_reg <= t1_a * t2_a;
        op_reg <= opcode;
    end

    assign a1 = $signed({47'd0, t1_reg});
    assign a2 = $signed({47'd0, t2_reg});
    assign s1 = $signed({30'd0, sq1_reg});
    assign s2 = $signed({30'd0, sq2_reg});
    assign mm = $signed({30'd0, m_reg});

    always_comb
    begin
        case (op_reg)
            OP_POSITION:
            begin
                e[0] = (a1 * s1 + 64'sd8388608) >>> 24;
                e[1] = (a2 * s2 + 64'sd8388608) >>> 24;
                e[2] = (a1 * mm + 64'sd8388608) >>> 24;
                e[3] = (a2 * mm + 64'sd8388608) >>> 24;
            end
            OP_GRADIENT:
            begin
                e[0] = (64'sd128 - 64'sd3 * s1) >>> 8;
                e[1] = (64'sd3 * s2 + 64'sd128) >>> 8;
                e[2] = (s1 - 64'sd2 * mm + 64'sd128) >>> 8;
                e[3] = (64'sd2 * mm - s2 + 64'sd128) >>> 8;
            end
            default:
            begin
                e[0] = a1 * 64'sd1536;
                e[1] = a2 * 64'sd1536;
                e[2] = (a2 - 64'sd2 * a1) * 64'sd512;
                e[3] = (a1 - 64'sd2 * a2) * 64'sd512;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            w_reg[i] <= e[i][WGT_W-1:0];
        end
    end

    assign weights = w_reg;

endmodule

>>> rtl/csse_lane.sv
module csse_lane
    import csse_pkg::*;
(
    input  logic    clk,
    input  logic    clear,
    input  logic    en,
    input  weight_t w,
    input  coord_t  d,
    output coord_t  result
);

    logic signed [ACC_W-1:0] acc_reg, acc_next, rnd;
    logic signed [WGT_W+DATA_W-1:0] prod;

    assign prod = w * d;

    always_comb
    begin
        acc_next = acc_reg;
        if (clear) acc_next = '0;
        else if (en) acc_next = acc_reg + ACC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign rnd = (acc_reg + 64'sd8388608) >>> 24;
    assign result = sat64(rnd);

endmodule

>>> rtl/cubic_spline_segment_evaluator.sv
// Cubic spline segment evaluator. Each request is one operation on a table of
// Q16.16 points and per-segment control vectors: write, read or append, or an
// evaluation of position, gradient or hessian at a segment and Q0.16 fraction.
// One request is processed at a time. Writes, range errors and appends to a
// full table go from dispatch straight to the result; reads add one table read,
// appends a read of both tables and two writes of the control table, and
// evaluations two reads of each table and a four step multiply-accumulate in
// each of three coordinate lanes. A new request is accepted while the previous
// result waits in the output register.
module cubic_spline_segment_evaluator
    import csse_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [5:0]  index,
    input  logic        side,
    input  logic [15:0] frac,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [1:0]  status
);

    localparam int PA = $clog2(MAX_POINTS);
    localparam int CA = PA + 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_RD1 = 4'd2;
    localparam logic [3:0] S_EV1 = 4'd3;
    localparam logic [3:0] S_EV2 = 4'd4;
    localparam logic [3:0] S_MAC = 4'd5;
    localparam logic [3:0] S_FIN = 4'd6;
    localparam logic [3:0] S_AP1 = 4'd7;
    localparam logic [3:0] S_AP2 = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0] mac_cnt_reg, mac_cnt_next;
    logic [1:0] pt_vld_reg, pt_vld_next, ct_vld_reg, ct_vld_next;
    logic out_valid_reg, out_valid_next;

    logic [2:0] op_reg;
    logic [5:0] index_reg;
    logic side_reg;
    logic [15:0] frac_reg;
    vec_t coord_reg;
    vec_t p0_reg, p1_reg, c0_reg, c1_reg;
    vec_t q_reg;
    vec_t res_reg, res_next;
    logic [1:0] res_st_reg, res_st_next;
    vec_t out_vec_reg;
    logic [1:0] out_st_reg;

    vec_t pt_mem [MAX_POINTS];
    vec_t ct_mem [2*MAX_POINTS];
    vec_t pt_rdata_reg, ct_rdata_reg, pt_rd, ct_rd, q_vec;
    logic pt_zero_reg, ct_zero_reg;
    logic pt_we, ct_we, pt_re, ct_re;
    logic [PA-1:0] pt_waddr, pt_raddr;
    logic [CA-1:0] ct_waddr, ct_raddr;
    vec_t pt_wdata, ct_wdata;

    logic [CMPW-1:0] idx_c, cnt_c, cnt_m1, cnt_m2, idx_p1;
    logic [CMPW:0] slot_w, ev_a, ev_b, ap_last, ap_new0, ap_new1;
    logic pt_err, ct_err, ev_err, full;

    weight_t weights [4];
    coord_t lane_res [3];
    logic lane_clear, lane_en;
    vec_t lane_sel;

    assign idx_c = CMPW'(index_reg);
    assign cnt_c = CMPW'(count_reg);
    assign cnt_m1 = cnt_c - 1'b1;
    assign cnt_m2 = cnt_c - 2'd2;
    assign idx_p1 = idx_c + 1'b1;
    assign slot_w = {idx_c, side_reg} - 1'b1;
    assign ev_a = {idx_c, 1'b0};
    assign ev_b = {idx_c, 1'b1};
    assign ap_last = {cnt_m2, 1'b1};
    assign ap_new0 = {cnt_m1, 1'b0};
    assign ap_new1 = {cnt_m1, 1'b1};

    assign pt_err = idx_c >= cnt_c;
    assign ct_err = pt_err || (idx_c == '0 && !side_reg) || (idx_c == cnt_m1 && side_reg);
    assign ev_err = idx_p1 >= cnt_c;
    assign full = count_reg == CW'(MAX_POINTS);

    assign pt_rd = pt_zero_reg ? '0 : pt_rdata_reg;
    assign ct_rd = ct_zero_reg ? '0 : ct_rdata_reg;

    assign q_vec = {reflect(pt_rd[95:64], ct_rd[95:64]),
                    reflect(pt_rd[63:32], ct_rd[63:32]),
                    reflect(pt_rd[31:0], ct_rd[31:0])};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mac_cnt_next = mac_cnt_reg;
        pt_vld_next = pt_vld_reg;
        ct_vld_next = ct_vld_reg;
        out_valid_next = out_valid_reg;
        res_next = res_reg;
        res_st_next = res_st_reg;
        pt_we = 1'b0;
        ct_we = 1'b0;
        pt_re = 1'b0;
        ct_re = 1'b0;
        pt_waddr = idx_c[PA-1:0];
        pt_raddr = idx_c[PA-1:0];
        ct_waddr = slot_w[CA-1:0];
        ct_raddr = slot_w[CA-1:0];
        pt_wdata = coord_reg;
        ct_wdata = coord_reg;
        lane_clear = 1'b0;
        lane_en = 1'b0;

        if (out_valid_reg && out_ready) out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) state_next = S_DISP;
            end
            S_DISP:
            begin
                res_next = '0;
                res_st_next = ST_OK;
                state_next = S_DONE;
                case (op_reg)
                    OP_WR_POINT:
                    begin
                        if (pt_err) res_st_next = ST_RANGE;
                        else
                        begin
                            pt_we = 1'b1;
                            if (idx_c < 2) pt_vld_next[idx_c[0]] = 1'b1;
                            res_next = coord_reg;
                        end
                    end
                    OP_WR_CTRL:
                    begin
                        if (ct_err) res_st_next = ST_RANGE;
                        else
                        begin
                            ct_we = 1'b1;
                            if (slot_w < 2) ct_vld_next[slot_w[0]] = 1'b1;
                            res_next = coord_reg;
                        end
                    end
                    OP_RD_POINT:
                    begin
                        if (pt_err) res_st_next = ST_RANGE;
                        else
                        begin
                            pt_re = 1'b1;
                            state_next = S_RD1;
                        end
                    end
                    OP_RD_CTRL:
                    begin
                        if (ct_err) res_st_next = ST_RANGE;
                        else
                        begin
                            ct_re = 1'b1;
                            state_next = S_RD1;
                        end
                    end
                    OP_APPEND:
                    begin
                        if (full) res_st_next = ST_FULL;
                        else
                        begin
                            pt_re = 1'b1;
                            ct_re = 1'b1;
                            pt_raddr = cnt_m1[PA-1:0];
                            ct_raddr = ap_last[CA-1:0];
                            state_next = S_AP1;
                        end
                    end
                    default:
                    begin
                        if (ev_err) res_st_next = ST_RANGE;
                        else
                        begin
                            pt_re = 1'b1;
                            ct_re = 1'b1;
                            ct_raddr = ev_a[CA-1:0];
                            state_next = S_EV1;
                        end
                    end
                endcase
            end
            S_RD1:
            begin
                res_next = (op_reg == OP_RD_POINT) ? pt_rd : ct_rd;
                state_next = S_DONE;
            end
            S_AP1:
            begin
                ct_we = 1'b1;
                ct_waddr = ap_new0[CA-1:0];
                ct_wdata = q_vec;
                pt_we = 1'b1;
                pt_waddr = count_reg[PA-1:0];
                state_next = S_AP2;
            end
            S_AP2:
            begin
                ct_we = 1'b1;
                ct_waddr = ap_new1[CA-1:0];
                ct_wdata = q_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_EV1:
            begin
                pt_re = 1'b1;
                ct_re = 1'b1;
                pt_raddr = idx_p1[PA-1:0];
                ct_raddr = ev_b[CA-1:0];
                state_next = S_EV2;
            end
            S_EV2:
            begin
                lane_clear = 1'b1;
                mac_cnt_next = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                lane_en = 1'b1;
                mac_cnt_next = mac_cnt_reg + 1'b1;
                if (mac_cnt_reg == 2'd3) state_next = S_FIN;
            end
            S_FIN:
            begin
                res_next = {lane_res[0], lane_res[1], lane_res[2]};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(2);
            mac_cnt_reg <= '0;
            pt_vld_reg <= '0;
            ct_vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mac_cnt_reg <= mac_cnt_next;
            pt_vld_reg <= pt_vld_next;
            ct_vld_reg <= ct_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= opcode;
            index_reg <= index;
            side_reg <= side;
            frac_reg <= frac;
            coord_reg <= {coord_x, coord_y, coord_z};
        end
        if (state_reg == S_EV1)
        begin
            p0_reg <= pt_rd;
            c0_reg <= ct_rd;
        end
        if (state_reg == S_EV2)
        begin
            p1_reg <= pt_rd;
            c1_reg <= ct_rd;
        end
        if (state_reg == S_AP1) q_reg <= q_vec;
        res_reg <= res_next;
        res_st_reg <= res_st_next;
        if (state_reg == S_DONE && (!out_valid_reg || out_ready))
        begin
            out_vec_reg <= res_reg;
            out_st_reg <= res_st_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
        if (pt_re)
        begin
            pt_rdata_reg <= pt_mem[pt_raddr];
            pt_zero_reg <= (pt_raddr < 2) && !pt_vld_reg[pt_raddr[0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ct_we) ct_mem[ct_waddr] <= ct_wdata;
        if (ct_re)
        begin
            ct_rdata_reg <= ct_mem[ct_raddr];
            ct_zero_reg <= (ct_raddr < 2) && !ct_vld_reg[ct_raddr[0]];
        end
    end

    csse_weights u_weights (
        .clk     (clk),
        .opcode  (op_reg),
        .frac    (frac_reg),
        .weights (weights)
    );

    always_comb
    begin
        case (mac_cnt_reg)
            2'd0: lane_sel = p0_reg;
            2'd1: lane_sel = p1_reg;
            2'd2: lane_sel = c0_reg;
            default: lane_sel = c1_reg;
        endcase
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        csse_lane u_lane (
            .clk    (clk),
            .clear  (lane_clear),
            .en     (lane_en),
            .w      (weights[mac_cnt_reg]),
            .d      (lane_sel[3*DATA_W-1-DATA_W*k -: DATA_W]),
            .result (lane_res[k])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_x = out_vec_reg[95:64];
    assign out_y = out_vec_reg[63:32];
    assign out_z = out_vec_reg[31:0];
    assign status = out_st_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CW'(2) && count_reg <= CW'(MAX_POINTS))
        else $error("Point count left its range.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("Point count changed by other than one.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("Undefined status code.");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        ct_we |-> (state_reg == S_DISP || state_reg == S_AP1 || state_reg == S_AP2))
        else $error("Control table written outside a write or append.");

endmodule

>>> tb/sv/cubic_spline_segment_evaluator_test.sv
`timescale 1ns / 100ps

module cubic_spline_segment_evaluator_test;
    import csse_pkg::*;

    localparam int POINTS = 64;
    localparam int N_RANDOM = 1750;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         st;
    } spline_result_t;

    class spline_scoreboard;
        coord_t         pt[3][POINTS];
        coord_t         ct[3][2*POINTS];
        int             count;
        int             errors;
        spline_result_t pending[$];

        function new();
            for (int a = 0; a < 3; a++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    pt[a][k] = '0;
                    ct[a][k] = '0;
                end
            end
            count = 2;
            errors = 0;
        endfunction

        function coord_t clamp(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return coord_t'(v);
        endfunction

        function longint rnd(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function int slot_of(int idx, bit sd);
            if (idx >= count)
                return -1;
            if (idx == 0 && sd == 0)
                return -1;
            if (idx == count - 1 && sd == 1)
                return -1;
            return 2 * idx + sd - 1;
        endfunction

        function void note(logic [2:0] op, int idx, bit sd, logic [15:0] fr,
                           coord_t cx, coord_t cy, coord_t cz);
            spline_result_t r;
            coord_t         v[3];
            coord_t         q;
            longint         w[4];
            longint         t1;
            longint         t2;
            longint         acc;
            int             sl;
            int             n;
            v[0] = cx;
            v[1] = cy;
            v[2] = cz;
            r.x = '0;
            r.y = '0;
            r.z = '0;
            r.st = ST_OK;
            t2 = longint'(fr);
            t1 = 65536 - t2;
            if (op == OP_WR_POINT || op == OP_RD_POINT)
            begin
                if (idx >= count)
                    r.st = ST_RANGE;
                else
                begin
                    if (op == OP_WR_POINT)
                        for (int a = 0; a < 3; a++)
                            pt[a][idx] = v[a];
                    r.x = pt[0][idx];
                    r.y = pt[1][idx];
                    r.z = pt[2][idx];
                end
            end
            else if (op == OP_WR_CTRL || op == OP_RD_CTRL)
            begin
                sl = slot_of(idx, sd);
                if (sl < 0)
                    r.st = ST_RANGE;
                else
                begin
                    if (op == OP_WR_CTRL)
                        for (int a = 0; a < 3; a++)
                            ct[a][sl] = v[a];
                    r.x = ct[0][sl];
                    r.y = ct[1][sl];
                    r.z = ct[2][sl];
                end
            end
            else if (op == OP_APPEND)
            begin
                n = count;
                if (n >= POINTS)
                    r.st = ST_FULL;
                else
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        q = clamp(2 * longint'(pt[a][n-1]) - longint'(ct[a][2*n-3]));
                        ct[a][2*n-2] = q;
                        ct[a][2*n-1] = q;
                        pt[a][n] = v[a];
                    end
                    count = n + 1;
                end
            end
            else
            begin
                if (idx + 1 >= count)
                    r.st = ST_RANGE;
                else
                begin
                    if (op == OP_POSITION)
                    begin
                        w[0] = rnd(t1 * t1 * t1, 24);
                        w[1] = rnd(t2 * t2 * t2, 24);
                        w[2] = rnd(t1 * t1 * t2, 24);
                        w[3] = rnd(t1 * t2 * t2, 24);
                    end
                    else if (op == OP_GRADIENT)
                    begin
                        w[0] = rnd(-3 * t1 * t1, 8);
                        w[1] = rnd(3 * t2 * t2, 8);
                        w[2] = rnd(-(2 * t2 - t1) * t1, 8);
                        w[3] = rnd((2 * t1 - t2) * t2, 8);
                    end
                    else
                    begin
                        w[0] = 6 * t1 * 256;
                        w[1] = 6 * t2 * 256;
                        w[2] = -2 * (2 * t1 - t2) * 256;
                        w[3] = -2 * (2 * t2 - t1) * 256;
                    end
                    for (int a = 0; a < 3; a++)
                    begin
                        acc = w[0] * longint'(pt[a][idx]) + w[1] * longint'(pt[a][idx+1])
                            + w[2] * longint'(ct[a][2*idx]) + w[3] * longint'(ct[a][2*idx+1]);
                        v[a] = clamp(rnd(acc, 24));
                    end
                    r.x = v[0];
                    r.y = v[1];
                    r.z = v[2];
                end
            end
            pending = {pending, r};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz, logic [1:0] gs);
            spline_result_t r;
            if (pending.size() == 0)
            begin
                $display("result with no request outstanding");
                errors++;
            end
            else
            begin
                r = pending.pop_front();
                if (gx !== r.x)
                    report("out_x", gx, r.x);
                if (gy !== r.y)
                    report("out_y", gy, r.y);
                if (gz !== r.z)
                    report("out_z", gz, r.z);
                if (gs !== r.st)
                    report("status", 32'(gs), 32'(r.st));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         opcode;
    logic [5:0]         index;
    logic               side;
    logic [15:0]        frac;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;

    spline_scoreboard sb;
    bit               quiet;
    int               cycles;

    cubic_spline_segment_evaluator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .index     (index),
        .side      (side),
        .frac      (frac),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_frac();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task send(logic [2:0] op, int idx, bit sd, logic [15:0] fr,
              logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        index <= idx[5:0];
        side <= sd;
        frac <= fr;
        coord_x <= cx;
        coord_y <= cy;
        coord_z <= cz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note(op, idx, sd, fr, cx, cy, cz);
    endtask

    task send_random();
        logic [2:0] op;
        int         idx;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 4)
            op = OP_APPEND;
        else
            op = 3'($urandom_range(0, 7) == OP_APPEND ? OP_POSITION : $urandom_range(0, 7));
        if ($urandom_range(0, 9) < 8)
            idx = $urandom_range(0, sb.count - 1);
        else
            idx = $urandom_range(0, 63);
        send(op, idx, 1'($urandom), pick_frac(), pick_coord(), pick_coord(), pick_coord());
    endtask

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check(out_x, out_y, out_z, status);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_RD_POINT;
        index = '0;
        side = 1'b0;
        frac = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_POSITION, 0, 0, 16'h8000, 0, 0, 0);
        send(OP_WR_POINT, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h0);
        send(OP_WR_POINT, 1, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send(OP_WR_CTRL, 0, 1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send(OP_WR_CTRL, 1, 0, 0, 32'h80000000, 32'h00010000, 32'h7FFFFFFF);
        send(OP_WR_CTRL, 0, 0, 0, 1, 2, 3);
        send(OP_WR_CTRL, 1, 1, 0, 1, 2, 3);
        send(OP_RD_CTRL, 0, 0, 0, 0, 0, 0);
        send(OP_RD_CTRL, 1, 0, 0, 0, 0, 0);
        send(OP_RD_POINT, 5, 0, 0, 0, 0, 0);
        send(OP_WR_POINT, 63, 1, 0, 1, 1, 1);
        send(OP_POSITION, 0, 0, 16'h0000, 0, 0, 0);
        send(OP_POSITION, 0, 1, 16'hFFFF, 0, 0, 0);
        send(OP_GRADIENT, 0, 0, 16'h0000, 0, 0, 0);
        send(OP_GRADIENT, 0, 0, 16'hFFFF, 0, 0, 0);
        send(OP_HESSIAN, 0, 0, 16'h0000, 0, 0, 0);
        send(OP_HESSIAN, 0, 0, 16'hFFFF, 0, 0, 0);
        send(OP_HESSIAN, 1, 0, 16'h1234, 0, 0, 0);
        send(OP_APPEND, 0, 0, 0, 32'h00030000, 32'hFFFD0000, 32'h7FFFFFFF);
        send(OP_RD_CTRL, 1, 1, 0, 0, 0, 0);
        send(OP_RD_CTRL, 2, 0, 0, 0, 0, 0);
        send(OP_RD_POINT, 2, 0, 0, 0, 0, 0);
        send(OP_POSITION, 1, 0, 16'h4000, 0, 0, 0);
        send(OP_GRADIENT, 2, 0, 16'h4000, 0, 0, 0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send_random();
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
